/* hdl/signed_int_to_decimal_ascii_unit_macros.svh */
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define SIDAU_ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// concurrent check on clk and arst_n
`define SIDAU_ASSERT(lbl, prop) \
	`SIDAU_ASSERT_AT(lbl, clk, arst_n, prop)

`endif

/* hdl/sidau_pkg.sv */
package sidau_pkg;

	localparam int VALUE_BITS      = 32;
	localparam int IN_BITS         = 32;
	localparam int CHAR_BITS       = 6;
	localparam int DIGIT_BITS      = 4;
	localparam int DIGITS          = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int IDX_BITS        = $clog2(DIGITS);
	localparam int STEPS_PER_STAGE = 8;
	localparam int DABBLE_STAGES   = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int DABBLE_BITS     = DABBLE_STAGES * STEPS_PER_STAGE;

	localparam logic [CHAR_BITS-1:0] MINUS_CODE = CHAR_BITS'(45);
	localparam logic [CHAR_BITS-1:0] DIGIT_BASE = CHAR_BITS'(48);
	localparam logic [CHAR_BITS-1:0] DIGIT_TOP  = CHAR_BITS'(57);

	typedef logic [DIGIT_BITS-1:0] digit_t;
	typedef logic [DIGITS-1:0][DIGIT_BITS-1:0] bcd_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	typedef struct packed {
		logic                   neg;
		bcd_t                   bcd;
		logic [DABBLE_BITS-1:0] bin;
	} dabble_t;

	typedef struct packed {
		logic neg;
		bcd_t bcd;
		idx_t top;
	} text_t;

endpackage

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// path: an input transfer passes the input register, four dabble stages and
// the leading-digit register before the serializer shows its first character
// throughput: one character per cycle while char_stall is low; an item gives
// 1 to 11 characters, sent by the single-character output serializer
// reset: asynchronous, clears all valid and busy flags; no clearing pass
module signed_int_to_decimal_ascii_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [sidau_pkg::IN_BITS-1:0] value,
	input  logic                            value_valid,
	output logic                            value_stall,
	output logic [sidau_pkg::CHAR_BITS-1:0] character,
	output logic                            last,
	output logic                            char_valid,
	input  logic                            char_stall
);

	logic [sidau_pkg::VALUE_BITS-1:0] raw;
	logic [sidau_pkg::VALUE_BITS-1:0] mag;
	logic                             neg;
	logic                             valid_s1;
	sidau_pkg::dabble_t               data_s1;
	logic                             adv_s1;

	logic               vld [sidau_pkg::DABBLE_STAGES+1];
	sidau_pkg::dabble_t dat [sidau_pkg::DABBLE_STAGES+1];
	logic               stl [sidau_pkg::DABBLE_STAGES+1];

	logic             valid_s6;
	sidau_pkg::text_t text_s6;
	logic             adv_s6;
	logic             ser_stall;

	function automatic sidau_pkg::idx_t top_digit(sidau_pkg::bcd_t b);
		sidau_pkg::idx_t t;
		t = '0;
		for (int k = 0; k < sidau_pkg::DIGITS; k++) begin
			if (b[k] != '0) begin
				t = sidau_pkg::IDX_BITS'(k);
			end
		end
		return t;
	endfunction

	// sign and magnitude
	assign raw         = value[sidau_pkg::VALUE_BITS-1:0];
	assign neg         = raw[sidau_pkg::VALUE_BITS-1];
	assign mag         = neg ? (~raw + 1'b1) : raw;
	assign adv_s1      = !(valid_s1 && stl[0]);
	assign value_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && value_valid) begin
			data_s1.neg <= neg;
			data_s1.bcd <= '0;
			data_s1.bin <= sidau_pkg::DABBLE_BITS'(mag);
		end
	end

	assign vld[0] = valid_s1;
	assign dat[0] = data_s1;

	// binary to bcd, shift-and-add-3
	for (genvar g = 0; g < sidau_pkg::DABBLE_STAGES; g++) begin : g_dabble
		sidau_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_data   (dat[g]),
			.in_stall  (stl[g]),
			.out_valid (vld[g+1]),
			.out_data  (dat[g+1]),
			.out_stall (stl[g+1])
		);
	end

	// leading digit position
	assign adv_s6  = !(valid_s6 && ser_stall);
	assign stl[sidau_pkg::DABBLE_STAGES] = !adv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv_s6) begin
			valid_s6 <= vld[sidau_pkg::DABBLE_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s6 && vld[sidau_pkg::DABBLE_STAGES]) begin
			text_s6.neg <= dat[sidau_pkg::DABBLE_STAGES].neg;
			text_s6.bcd <= dat[sidau_pkg::DABBLE_STAGES].bcd;
			text_s6.top <= top_digit(dat[sidau_pkg::DABBLE_STAGES].bcd);
		end
	end

	sidau_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s6),
		.in_text    (text_s6),
		.in_stall   (ser_stall),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.last       (last)
	);

endmodule

/* hdl/sidau_dabble_stage.sv */
module sidau_dabble_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sidau_pkg::dabble_t in_data,
	output logic              in_stall,
	output logic              out_valid,
	output sidau_pkg::dabble_t out_data,
	input  logic              out_stall
);

	logic               valid_sn;
	sidau_pkg::dabble_t data_sn;
	logic               advance;

	function automatic sidau_pkg::dabble_t dabble_steps(sidau_pkg::dabble_t d);
		sidau_pkg::dabble_t r;
		r = d;
		for (int s = 0; s < sidau_pkg::STEPS_PER_STAGE; s++) begin
			for (int k = 0; k < sidau_pkg::DIGITS; k++) begin
				if (r.bcd[k] >= sidau_pkg::DIGIT_BITS'(5)) begin
					r.bcd[k] = r.bcd[k] + sidau_pkg::DIGIT_BITS'(3);
				end
			end
			{r.bcd, r.bin} = {r.bcd, r.bin} << 1;
		end
		return r;
	endfunction

	assign advance   = !(valid_sn && out_stall);
	assign in_stall  = !advance;
	assign out_valid = valid_sn;
	assign out_data  = data_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (advance) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_sn <= dabble_steps(in_data);
		end
	end

endmodule

/* hdl/sidau_serializer.sv */
module sidau_serializer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  sidau_pkg::text_t                     in_text,
	output logic                                 in_stall,
	output logic                                 char_valid,
	input  logic                                 char_stall,
	output logic [sidau_pkg::CHAR_BITS-1:0]      character,
	output logic                                 last
);

	logic              busy_q;
	logic              sign_q;
	sidau_pkg::idx_t   pos_q;
	sidau_pkg::bcd_t   bcd_q;
	sidau_pkg::digit_t cur_digit;
	logic              xfer;
	logic              done;
	logic              load;

	always_comb begin
		cur_digit = bcd_q[pos_q];
		character = sign_q ? sidau_pkg::MINUS_CODE
		                   : sidau_pkg::DIGIT_BASE + sidau_pkg::CHAR_BITS'(cur_digit);
		last      = !sign_q && (pos_q == '0);
	end

	assign char_valid = busy_q;
	assign xfer       = busy_q && !char_stall;
	assign done       = xfer && last;
	assign load       = in_valid && (!busy_q || done);
	assign in_stall   = busy_q && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sign_q <= in_text.neg;
			pos_q  <= in_text.top;
			bcd_q  <= in_text.bcd;
		end else if (xfer) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/sidau_checker.sv */
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sidau_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            char_valid,
	input logic                            char_stall,
	input logic [sidau_pkg::CHAR_BITS-1:0] character,
	input logic                            last
);

	`SIDAU_ASSERT(a_char_hold, char_valid && char_stall |=> char_valid && $stable(character) && $stable(last))
	`SIDAU_ASSERT(a_char_code, char_valid |-> (character == sidau_pkg::MINUS_CODE) || (character >= sidau_pkg::DIGIT_BASE && character <= sidau_pkg::DIGIT_TOP))
	`SIDAU_ASSERT(a_minus_not_last, char_valid && (character == sidau_pkg::MINUS_CODE) |-> !last)
	`SIDAU_ASSERT(a_digit_after_minus, char_valid && !char_stall && (character == sidau_pkg::MINUS_CODE) |=> char_valid && (character != sidau_pkg::MINUS_CODE))

endmodule

bind signed_int_to_decimal_ascii_unit sidau_checker u_checker (.*);

/* tb/decimal_text_checker.sv */
`timescale 1ns / 100ps

module decimal_text_checker
	import sidau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_BITS-1:0]   value,
	input  logic                 value_valid,
	input  logic                 value_stall,
	input  logic [CHAR_BITS-1:0] character,
	input  logic                 last,
	input  logic                 char_valid,
	input  logic                 char_stall,
	output int                   errors,
	output int                   pending
);

	typedef struct {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} text_char_t;

	text_char_t expected_chars[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 50)
			$display("%0t: mismatch: %s", $time, msg);
		errors++;
	endtask

	// decimal text of one value, sign first, most significant digit next
	function automatic void queue_decimal_text(input logic [IN_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] bits;
		logic [VALUE_BITS-1:0] mag;
		logic [DIGIT_BITS-1:0] digits[$];
		text_char_t            c;
		bits = raw[VALUE_BITS-1:0];
		mag = bits[VALUE_BITS-1] ? (~bits + 1'b1) : bits;
		do begin
			digits.push_front(DIGIT_BITS'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (bits[VALUE_BITS-1]) begin
			c.code = MINUS_CODE;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		while (digits.size() > 0) begin
			c.code = DIGIT_BASE + CHAR_BITS'(digits.pop_front());
			c.last = (digits.size() == 0);
			expected_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			// output side first so that a stray character cannot match a fresh value
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %0d with no value pending", character));
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.code)
						report_mismatch($sformatf("character got %0d want %0d",
							character, want.code));
					if (last !== want.last)
						report_mismatch($sformatf("last got %b want %b on character %0d",
							last, want.last, want.code));
				end
			end
			if (value_valid && !value_stall)
				queue_decimal_text(value);
			pending = expected_chars.size();
		end
	end

endmodule

/* tb/signed_int_to_decimal_ascii_unit_test.sv */
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_test;
	import sidau_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 112;

	logic                      clk;
	logic                      arst_n;
	logic signed [IN_BITS-1:0] value;
	logic                      value_valid;
	logic                      value_stall;
	logic [CHAR_BITS-1:0]      character;
	logic                      last;
	logic                      char_valid;
	logic                      char_stall;

	int errors;
	int pending;
	int cycle_count;
	int send_idle_pct;
	int stall_pct;
	logic hold_off;
	logic pressure_go;

	signed_int_to_decimal_ascii_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.character   (character),
		.last        (last),
		.char_valid  (char_valid),
		.char_stall  (char_stall)
	);

	decimal_text_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.character   (character),
		.last        (last),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.errors      (errors),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		char_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
	end

	// long receiver hold-off while values keep coming, fills the block
	initial begin
		hold_off = 1'b0;
		wait (pressure_go);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (300) @(negedge clk);
		hold_off = 1'b0;
	end

	task automatic send_value(input logic [IN_BITS-1:0] v);
		logic accepted;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			value_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		value <= v;
		value_valid <= 1'b1;
		do begin
			@(negedge clk);
			accepted = !value_stall;
			@(posedge clk);
		end while (!accepted);
	endtask

	function automatic logic [IN_BITS-1:0] random_value();
		int unsigned p;
		int unsigned mag;
		int          k;
		logic [IN_BITS-1:0] v;
		k = $urandom_range(0, 9);
		p = 1;
		repeat (k) p = p * 10;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: mag = $urandom_range(0, (k == 9) ? 32'h7FFFFFFF : p * 10 - 1);
			2: mag = p + $urandom_range(0, 2) - 1;
			3: begin
				if ($urandom_range(0, 1))
					return 32'h80000000 + $urandom_range(0, 3);
				return 32'h7FFFFFFF - $urandom_range(0, 3);
			end
			default: mag = $urandom_range(0, 20);
		endcase
		v = mag;
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	initial begin
		logic [IN_BITS-1:0] directed[$];
		arst_n <= 1'b0;
		value <= '0;
		value_valid <= 1'b0;
		pressure_go = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd5, 32'd7, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000,
			32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h55555555,
			32'hAAAAAAAA, 32'd147483648, -32'sd147483648, 32'd12345678};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) send_value(directed[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  pressure_go = 1'b1; end
				1: begin send_idle_pct = 62; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 62; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			repeat (ITEMS_PER_PHASE) send_value(random_value());
		end
		value_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
